// File: hdl/xec_pkg.sv
// shared constants, types and reset values for the xor erasure code engine
package xec_pkg;

   localparam int DATA_COUNT    = 12;
   localparam int PARITY_COUNT  = 6;
   localparam int ELEM_COUNT    = DATA_COUNT + PARITY_COUNT;
   localparam int WORD_BITS     = 64;
   localparam int IDX_BITS      = 5;
   localparam int DIDX_BITS     = $clog2(DATA_COUNT);
   localparam int PIDX_BITS     = $clog2(PARITY_COUNT);
   localparam int DCNT_BITS     = $clog2(DATA_COUNT + 1);
   localparam int PCNT_BITS     = $clog2(PARITY_COUNT + 1);
   localparam int SLOT_COUNT    = PARITY_COUNT + 1;
   localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
   localparam int MODE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = ELEM_COUNT;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 72;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_BITS-1:0] MODE_ENCODE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DECODE = 2'd1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MISSING = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PMASK0  = 3'd2;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [DATA_COUNT-1:0] dmask_type;

   localparam dmask_type [PARITY_COUNT-1:0] PMASK_RESET = {
      12'd2872, 12'd1436, 12'd718, 12'd2375, 12'd3235, 12'd1649
   };

   typedef struct packed {
      logic [MODE_BITS-1:0]         mode;
      logic [ELEM_COUNT-1:0]        missing;
      dmask_type [PARITY_COUNT-1:0] pmask;
   } cfg_type;

   typedef struct packed {
      word_type [PARITY_COUNT-1:0] accum;
      word_type [PARITY_COUNT-1:0] recv;
   } column_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hdl/xor_erasure_code_engine.sv
// top level of the flat xor erasure code engine
//
// usage: element words of one stripe column enter on the req_ stream, one word
// per beat, tagged with the element index; req_tlast marks the last word of
// the column. encode emits every parity word, decode emits the rebuilt data
// word and, in regenerate mode, the missing parity words; an unsupported
// failure pattern gives a single beat with status set.
// input rate is one beat per cycle; words only fold into the accumulators.
// a closed column goes through a two-entry column queue to the back part,
// which sends one result beat per cycle; the column is held in the queue, then
// in the working column, and its results in the output register on rsp_.
// a column occupies the back part until its results are sent, so a long run
// of one-word columns is limited by the result count, not the input.
// if rsp_tready stays low the output register holds, the back part waits and,
// once the queue holds two columns, req_tready falls.
// reset clears the accumulators, the queue and the output stage and loads the
// default mode, missing mask and parity masks. csr_ writes must come while idle (not enforced).
module xor_erasure_code_engine import xec_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // element_index, data_word, zero fill
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // out_index, result_word, zero fill
   output logic                     rsp_tlast,
   output logic                     rsp_tuser,  // status
   input  logic                     csr_wen,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type             cfg_ff, cfg_in;
   qstat_type           qstat;
   logic                push, pop;
   column_type          push_data, head;
   logic [IDX_BITS-1:0] out_index;
   word_type            out_word;
   logic [CSR_IDX_BITS-1:0] pm_sel;

   assign pm_sel = csr_index - CSR_PMASK0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_MODE:    cfg_in.mode    = csr_wdata[MODE_BITS-1:0];
            CSR_MISSING: cfg_in.missing = csr_wdata[ELEM_COUNT-1:0];
            default:     cfg_in.pmask[pm_sel[PIDX_BITS-1:0]] = csr_wdata[DATA_COUNT-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_ENCODE;
         cfg_ff.missing <= '0;
         cfg_ff.pmask   <= PMASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   xec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_index  (req_tdata[IDX_BITS-1:0]),
      .in_word   (req_tdata[IDX_BITS +: WORD_BITS]),
      .in_last   (req_tlast),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   xec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   xec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_index  (out_index),
      .out_word   (out_word),
      .out_last   (rsp_tlast),
      .out_status (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - WORD_BITS - IDX_BITS){1'b0}}, out_word, out_index};

endmodule

// File: hdl/xec_front.sv
// front part: takes word beats, folds them into the parity accumulators, closes columns
module xec_front import xec_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [IDX_BITS-1:0] in_index,
   input  word_type            in_word,
   input  logic                in_last,
   input  qstat_type           qstat,
   output logic                push,
   output column_type          push_data
);

   word_type [PARITY_COUNT-1:0] accum_ff, accum_in, accum_upd;
   word_type [PARITY_COUNT-1:0] recv_ff, recv_in, recv_upd;
   logic                        accept;
   logic                        dropped;
   logic [IDX_BITS-1:0]         pidx;

   assign in_ready = !qstat.full;
   assign accept   = in_valid && !qstat.full;
   assign dropped  = (cfg.mode != MODE_ENCODE) && (in_index < IDX_BITS'(ELEM_COUNT))
                     && cfg.missing[in_index];
   assign pidx     = in_index - IDX_BITS'(DATA_COUNT);

   always_comb begin
      accum_upd = accum_ff;
      recv_upd  = recv_ff;
      if (!dropped) begin
         if (in_index < IDX_BITS'(DATA_COUNT)) begin
            for (int j = 0; j < PARITY_COUNT; j++) begin
               if (cfg.pmask[j][in_index[DIDX_BITS-1:0]]) begin
                  accum_upd[j] = accum_ff[j] ^ in_word;
               end
            end
         end else if (in_index < IDX_BITS'(ELEM_COUNT)) begin
            recv_upd[pidx[PIDX_BITS-1:0]] = in_word;
         end
      end
   end

   always_comb begin
      accum_in        = accum_ff;
      recv_in         = recv_ff;
      push            = 1'b0;
      push_data.accum = accum_upd;
      push_data.recv  = recv_upd;
      if (accept) begin
         if (in_last) begin
            accum_in = '0;
            recv_in  = '0;
            push     = 1'b1;
         end else begin
            accum_in = accum_upd;
            recv_in  = recv_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         recv_ff  <= '0;
      end else begin
         accum_ff <= accum_in;
         recv_ff  <= recv_in;
      end
   end

endmodule

// File: hdl/xec_queue.sv
// two-entry queue of closed columns between front and back
module xec_queue import xec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  column_type push_data,
   input  logic       pop,
   output column_type head,
   output qstat_type  qstat
);

   column_type [QUEUE_DEPTH-1:0] entries_ff;
   logic [QPTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]         count_ff, count_in;

   assign head        = entries_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("push into full column queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("pop from empty column queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !qstat.full) |=> (count_ff == $past(count_ff) + QCNT_BITS'(1)))
      else $error("column queue count lost a push");
`endif

endmodule

// File: hdl/xec_back.sv
// back part: turns a closed column into parity, rebuilt or status beats
module xec_back import xec_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  column_type          head,
   input  qstat_type           qstat,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [IDX_BITS-1:0] out_index,
   output word_type            out_word,
   output logic                out_last,
   output logic                out_status
);

   logic [DATA_COUNT-1:0]   miss_d;
   logic [PARITY_COUNT-1:0] miss_p;
   logic [DCNT_BITS-1:0]    nd;
   logic [PCNT_BITS-1:0]    np;
   logic [DIDX_BITS-1:0]    dsel;
   logic [PIDX_BITS-1:0]    psel;
   logic                    dfound, pfound, one_miss, fail;
   logic [SLOT_COUNT-1:0]   todo_init;

   column_type              work_ff, work_in;
   logic [SLOT_COUNT-1:0]   todo_ff, todo_in;
   logic [SLOT_COUNT-1:0]   slot_hot, todo_rest;
   logic [SLOT_BITS-1:0]    sidx;
   logic [PIDX_BITS-1:0]    pj;
   logic                    emit, free;
   word_type                rebuilt, pword;

   logic                    out_valid_ff, out_valid_in;
   logic [IDX_BITS-1:0]     out_index_ff, out_index_in;
   word_type                out_word_ff, out_word_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_status_ff, out_status_in;

   // failure pattern analysis, config only
   assign miss_d   = cfg.missing[DATA_COUNT-1:0];
   assign miss_p   = cfg.missing[ELEM_COUNT-1:DATA_COUNT];
   assign nd       = DCNT_BITS'($countones(miss_d));
   assign np       = PCNT_BITS'($countones(miss_p));
   assign one_miss = (nd == DCNT_BITS'(1));

   always_comb begin
      dsel   = '0;
      dfound = 1'b0;
      for (int i = 0; i < DATA_COUNT; i++) begin
         if (miss_d[i] && !dfound) begin
            dsel   = DIDX_BITS'(i);
            dfound = 1'b1;
         end
      end
   end

   always_comb begin
      psel   = '0;
      pfound = 1'b0;
      for (int j = 0; j < PARITY_COUNT; j++) begin
         if (cfg.pmask[j][dsel] && !miss_p[j] && !pfound) begin
            psel   = PIDX_BITS'(j);
            pfound = 1'b1;
         end
      end
   end

   assign fail = (nd > DCNT_BITS'(1))
                 || ((5'(nd) + 5'(np)) > 5'd3)
                 || (one_miss && !pfound);

   always_comb begin
      if (cfg.mode == MODE_ENCODE) begin
         todo_init = {{PARITY_COUNT{1'b1}}, 1'b0};
      end else if (fail) begin
         todo_init = SLOT_COUNT'(1);
      end else begin
         todo_init = {(cfg.mode != MODE_DECODE) ? miss_p : {PARITY_COUNT{1'b0}}, one_miss};
      end
   end

   // slot walk over the working column
   assign emit      = (todo_ff != '0) && (!out_valid_ff || out_ready);
   assign slot_hot  = todo_ff & (~todo_ff + SLOT_COUNT'(1));
   assign todo_rest = todo_ff & ~slot_hot;
   assign free      = (todo_ff == '0) || (emit && (todo_rest == '0));
   assign pop       = !qstat.empty && free;

   always_comb begin
      sidx = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (slot_hot[s]) begin
            sidx = SLOT_BITS'(s);
         end
      end
   end

   assign pj      = PIDX_BITS'(sidx - SLOT_BITS'(1));
   assign rebuilt = work_ff.recv[psel] ^ work_ff.accum[psel];
   assign pword   = work_ff.accum[pj]
                    ^ (((cfg.mode != MODE_ENCODE) && one_miss && cfg.pmask[pj][dsel])
                       ? rebuilt : '0);

   always_comb begin
      work_in = work_ff;
      todo_in = todo_ff;
      if (pop) begin
         work_in = head;
         todo_in = todo_init;
      end else if (emit) begin
         todo_in = todo_rest;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_index_in  = out_index_ff;
      out_word_in   = out_word_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = (todo_rest == '0);
         if (sidx == '0) begin
            out_status_in = fail;
            out_index_in  = fail ? '0 : IDX_BITS'(dsel);
            out_word_in   = fail ? '0 : rebuilt;
         end else begin
            out_status_in = 1'b0;
            out_index_in  = IDX_BITS'(DATA_COUNT) + IDX_BITS'(pj);
            out_word_in   = pword;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      out_index_ff  <= out_index_in;
      out_word_ff   <= out_word_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         todo_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         todo_ff      <= todo_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_index  = out_index_ff;
   assign out_word   = out_word_ff;
   assign out_last   = out_last_ff;
   assign out_status = out_status_ff;

endmodule

// File: sim/xor_erasure_code_engine_tb.sv
// testbench for the xor erasure code engine: directed and random stripe columns against a predictor
`timescale 1ns / 100ps

module xor_erasure_code_engine_tb import xec_pkg::*; ();

   localparam logic [MODE_BITS-1:0] MODE_REGEN = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;
   localparam word_type ALL_ONES = '1;
   localparam int ITEM_TARGET   = 280;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [IDX_BITS-1:0] index;
      word_type            word;
      logic                last;
      logic                status;
   } rsp_beat_type;

   typedef struct packed {
      logic                     is_cfg;
      logic [CSR_IDX_BITS-1:0]  reg_sel;
      logic [CSR_DATA_BITS-1:0] value;
      logic [IDX_BITS-1:0]      elem;
      word_type                 word;
      logic                     last;
      logic                     typed;
      rsp_beat_type             want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;  // element_index, data_word, zero fill
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;  // out_index, result_word, zero fill
   logic                     rsp_tlast;
   logic                     rsp_tuser;  // status
   logic                     csr_wen;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   xor_erasure_code_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [MODE_BITS-1:0]  mdl_mode;
   logic [ELEM_COUNT-1:0] mdl_missing;
   dmask_type             mdl_pmask [PARITY_COUNT];
   word_type              fold_acc [PARITY_COUNT];
   word_type              parity_rx [PARITY_COUNT];
   rsp_beat_type          column_out[$];
   rsp_beat_type          pending_results[$];
   logic                  word_ignored;

   int   errors = 0;
   int   results_seen = 0;
   int   words_sent = 0;
   int   useful_items = 0;
   int   columns_closed = 0;
   int   cfg_writes = 0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   logic column_open = 1'b0;

   function automatic rsp_beat_type make_beat(input int index, input word_type word,
                                              input logic status);
      rsp_beat_type b;
      b.index  = index[IDX_BITS-1:0];
      b.word   = word;
      b.last   = 1'b0;
      b.status = status;
      return b;
   endfunction

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_BITS-1:0] sel,
                                            input logic [CSR_DATA_BITS-1:0] value);
      stim_row_type r;
      r = '0;
      r.is_cfg  = 1'b1;
      r.reg_sel = sel;
      r.value   = value;
      return r;
   endfunction

   function automatic stim_row_type beat_row(input int elem, input word_type word,
                                             input logic last);
      stim_row_type r;
      r = '0;
      r.elem = elem[IDX_BITS-1:0];
      r.word = word;
      r.last = last;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input int elem, input word_type word,
                                              input int index, input word_type result,
                                              input logic status);
      stim_row_type r;
      r = beat_row(elem, word, 1'b1);
      r.typed = 1'b1;
      r.want = make_beat(index, result, status);
      r.want.last = 1'b1;
      return r;
   endfunction

   task automatic fold_beat(input logic [IDX_BITS-1:0] e, input word_type w, input logic last);
      int           nd, np, d, p;
      logic         fail;
      word_type     rebuilt, v;
      rsp_beat_type tail;
      column_out.delete();
      word_ignored = e >= ELEM_COUNT || (mdl_mode != MODE_ENCODE && mdl_missing[e]);
      if (!word_ignored) begin
         if (e < DATA_COUNT) begin
            for (int j = 0; j < PARITY_COUNT; j++)
               if (mdl_pmask[j][e]) fold_acc[j] ^= w;
         end else begin
            parity_rx[e - DATA_COUNT] = w;
         end
      end
      if (last) begin
         if (mdl_mode == MODE_ENCODE) begin
            for (int j = 0; j < PARITY_COUNT; j++)
               column_out.push_back(make_beat(DATA_COUNT + j, fold_acc[j], STATUS_OK));
         end else begin
            nd = 0;
            np = 0;
            d = -1;
            p = -1;
            fail = 1'b0;
            rebuilt = '0;
            for (int j = 0; j < DATA_COUNT; j++)
               if (mdl_missing[j]) begin
                  if (d < 0) d = j;
                  nd++;
               end
            for (int j = 0; j < PARITY_COUNT; j++)
               if (mdl_missing[DATA_COUNT + j]) np++;
            if (nd >= 2 || nd + np > 3) fail = 1'b1;
            if (!fail && nd == 1) begin
               // lowest available parity that covers the lost word
               for (int j = PARITY_COUNT - 1; j >= 0; j--)
                  if (mdl_pmask[j][d] && !mdl_missing[DATA_COUNT + j]) p = j;
               if (p < 0) fail = 1'b1;
               else rebuilt = parity_rx[p] ^ fold_acc[p];
            end
            if (fail) begin
               column_out.push_back(make_beat(0, '0, STATUS_FAIL));
            end else begin
               if (nd == 1) column_out.push_back(make_beat(d, rebuilt, STATUS_OK));
               if (mdl_mode != MODE_DECODE) begin
                  for (int j = 0; j < PARITY_COUNT; j++)
                     if (mdl_missing[DATA_COUNT + j]) begin
                        v = fold_acc[j];
                        if (nd == 1 && mdl_pmask[j][d]) v ^= rebuilt;
                        column_out.push_back(make_beat(DATA_COUNT + j, v, STATUS_OK));
                     end
               end
            end
         end
         if (column_out.size() > 0) begin
            tail = column_out.pop_back();
            tail.last = 1'b1;
            column_out.push_back(tail);
         end
         for (int j = 0; j < PARITY_COUNT; j++) begin
            fold_acc[j] = '0;
            parity_rx[j] = '0;
         end
         columns_closed++;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] sel,
                            input logic [CSR_DATA_BITS-1:0] value);
      if (column_open) begin
         req_tvalid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         column_open = 1'b0;
      end
      csr_wen   <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      case (sel)
         CSR_MODE:    mdl_mode = value[MODE_BITS-1:0];
         CSR_MISSING: mdl_missing = value[ELEM_COUNT-1:0];
         default:     mdl_pmask[sel - CSR_PMASK0] = value[DATA_COUNT-1:0];
      endcase
      cfg_writes++;
   endtask

   task automatic send_beat(input logic [IDX_BITS-1:0] elem, input word_type word,
                            input logic last, input logic calm, input logic typed,
                            input rsp_beat_type want);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (csr_wen) csr_wen <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS - IDX_BITS - WORD_BITS){1'b0}}, word, elem};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      fold_beat(elem, word, last);
      if (typed) pending_results.push_back(want);
      else foreach (column_out[k]) pending_results.push_back(column_out[k]);
      column_open = 1'b1;
      words_sent++;
      if (!word_ignored) useful_items++;
   endtask

   task automatic field_check(input string name, input logic [WORD_BITS-1:0] want,
                              input logic [WORD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_beat;
      rsp_beat_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, got index %0d word %h last %b st %b",
                  $time, rsp_tdata[IDX_BITS-1:0], rsp_tdata[IDX_BITS +: WORD_BITS], rsp_tlast,
                  rsp_tuser);
         errors++;
      end else begin
         want = pending_results.pop_front();
         field_check("out_index", WORD_BITS'(want.index), WORD_BITS'(rsp_tdata[IDX_BITS-1:0]));
         field_check("result_word", want.word, rsp_tdata[IDX_BITS +: WORD_BITS]);
         field_check("result_last", WORD_BITS'(want.last), WORD_BITS'(rsp_tlast));
         field_check("status", WORD_BITS'(want.status), WORD_BITS'(rsp_tuser));
      end
      results_seen++;
   endtask

   initial begin : rsp_side
      int   stall;
      logic calm;
      calm = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         // one long hold-off so the column queue fills and the input stalls
         if (hold_req && !hold_done) begin
            stall = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_beat();
         if ($urandom_range(0, 15) == 0) calm = !calm;
      end
   end

   initial begin : req_side
      stim_row_type             rows[$];
      logic [IDX_BITS-1:0]      elems[$];
      logic [ELEM_COUNT-1:0]    miss;
      logic [MODE_BITS-1:0]     m;
      logic [CSR_IDX_BITS-1:0]  sel;
      logic [CSR_DATA_BITS-1:0] v;
      logic                     calm, take;
      int                       kind, ncol;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_wen    <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      mdl_mode    = MODE_ENCODE;
      mdl_missing = '0;
      for (int j = 0; j < PARITY_COUNT; j++) begin
         mdl_pmask[j] = PMASK_RESET[j];
         fold_acc[j]  = '0;
         parity_rx[j] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // encode with reset masks, parity and out of range words
      rows.push_back(beat_row(0, ALL_ONES, 1'b0));
      rows.push_back(beat_row(11, 64'h1, 1'b0));
      rows.push_back(beat_row(17, 64'h0123_4567_89AB_CDEF, 1'b0));
      rows.push_back(beat_row(31, ALL_ONES, 1'b0));
      rows.push_back(beat_row(6, 64'h8000_0000_0000_0000, 1'b1));
      rows.push_back(beat_row(20, ALL_ONES, 1'b1));
      // mask extremes
      rows.push_back(cfg_row(CSR_PMASK0, 18'h3FFFF));
      rows.push_back(cfg_row(CSR_PMASK0 + 3'd1, 18'h0));
      rows.push_back(cfg_row(CSR_PMASK0 + 3'd2, 18'h0));
      rows.push_back(cfg_row(CSR_PMASK0 + 3'd3, 18'h3F000));
      rows.push_back(cfg_row(CSR_PMASK0 + 3'd4, 18'h00FFF));
      rows.push_back(beat_row(5, 64'h5A5A_0F0F_C3C3_9696, 1'b1));
      // single lost data word rebuilt from parity 0
      rows.push_back(cfg_row(CSR_MODE, CSR_DATA_BITS'(MODE_DECODE)));
      rows.push_back(cfg_row(CSR_MISSING, 18'h00001));
      for (int j = 0; j < 5; j++)
         rows.push_back(cfg_row(CSR_PMASK0 + j[CSR_IDX_BITS-1:0],
                                CSR_DATA_BITS'(PMASK_RESET[j])));
      rows.push_back(beat_row(0, ALL_ONES, 1'b0));
      rows.push_back(beat_row(12, 64'hDEAD_BEEF_0BAD_F00D, 1'b0));
      rows.push_back(typed_row(31, ALL_ONES, 0, 64'hDEAD_BEEF_0BAD_F00D, STATUS_OK));
      // nothing lost, nothing to send
      rows.push_back(cfg_row(CSR_MISSING, 18'h0));
      rows.push_back(beat_row(3, 64'h0000_0000_0000_0001, 1'b1));
      // two lost data words, then too many losses
      rows.push_back(cfg_row(CSR_MISSING, 18'h00003));
      rows.push_back(typed_row(2, 64'h0000_0000_0000_0001, 0, '0, STATUS_FAIL));
      rows.push_back(cfg_row(CSR_MISSING, 18'h0E001));
      rows.push_back(typed_row(1, 64'h0000_0000_0000_0001, 0, '0, STATUS_FAIL));
      // lost data word with no surviving parity covering it
      rows.push_back(cfg_row(CSR_MODE, CSR_DATA_BITS'(MODE_REGEN)));
      rows.push_back(cfg_row(CSR_MISSING, 18'h06800));
      rows.push_back(cfg_row(CSR_PMASK0 + 3'd5, 18'h0));
      rows.push_back(typed_row(11, ALL_ONES, 0, '0, STATUS_FAIL));
      // mode 3 rebuilds data 4 and regenerates parity 0
      rows.push_back(cfg_row(CSR_MODE, CSR_DATA_BITS'(MODE_SPARE)));
      rows.push_back(cfg_row(CSR_MISSING, 18'h01010));
      rows.push_back(cfg_row(CSR_PMASK0 + 3'd5, CSR_DATA_BITS'(PMASK_RESET[5])));
      rows.push_back(beat_row(16, 64'hFEDC_BA98_7654_3210, 1'b0));
      rows.push_back(beat_row(2, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0));
      rows.push_back(beat_row(4, ALL_ONES, 1'b0));
      rows.push_back(beat_row(12, ALL_ONES, 1'b1));
      // parities only lost: regenerated, then silent in data-only decode
      rows.push_back(cfg_row(CSR_MODE, CSR_DATA_BITS'(MODE_REGEN)));
      rows.push_back(cfg_row(CSR_MISSING, 18'h28000));
      rows.push_back(beat_row(9, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1));
      rows.push_back(cfg_row(CSR_MODE, CSR_DATA_BITS'(MODE_DECODE)));
      rows.push_back(beat_row(9, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1));

      foreach (rows[i]) begin
         if (rows[i].is_cfg) write_reg(rows[i].reg_sel, rows[i].value);
         else send_beat(rows[i].elem, rows[i].word, rows[i].last, 1'b0, rows[i].typed,
                        rows[i].want);
      end

      // back pressure: encode columns at full rate while the result side holds off
      write_reg(CSR_MODE, CSR_DATA_BITS'(MODE_ENCODE));
      hold_req = 1'b1;
      repeat (6) begin
         send_beat(IDX_BITS'($urandom_range(0, DATA_COUNT - 1)), {$urandom, $urandom},
                   1'b0, 1'b1, 1'b0, '0);
         send_beat(IDX_BITS'($urandom_range(0, DATA_COUNT - 1)), {$urandom, $urandom},
                   1'b1, 1'b1, 1'b0, '0);
      end

      while (words_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         miss = '0;
         if (kind <= 5) begin
            if ($urandom_range(0, 1)) miss[$urandom_range(0, DATA_COUNT - 1)] = 1'b1;
            repeat ($urandom_range(0, 2))
               miss[DATA_COUNT + $urandom_range(0, PARITY_COUNT - 1)] = 1'b1;
         end else if (kind == 6) begin
            miss[$urandom_range(0, 5)] = 1'b1;
            miss[$urandom_range(6, DATA_COUNT - 1)] = 1'b1;
         end else if (kind == 7) begin
            miss = ELEM_COUNT'($urandom_range(0, (1 << ELEM_COUNT) - 1));
         end else if (kind == 8) begin
            miss[$urandom_range(0, DATA_COUNT - 1)] = 1'b1;
            miss[DATA_COUNT + $urandom_range(0, 3) +: 3] = 3'b111;
         end
         m = ($urandom_range(0, 2) == 0) ? MODE_ENCODE : MODE_BITS'($urandom_range(1, 3));
         if ($urandom_range(0, 3) == 0) begin
            for (int j = 0; j < PARITY_COUNT; j++) begin
               case ($urandom_range(0, 5))
                  0:       v = '0;
                  1:       v = '1;
                  default: v = CSR_DATA_BITS'($urandom_range(0, (1 << CSR_DATA_BITS) - 1));
               endcase
               sel = CSR_PMASK0 + CSR_IDX_BITS'(j);
               write_reg(sel, v);
            end
         end
         write_reg(CSR_MODE, CSR_DATA_BITS'(m));
         write_reg(CSR_MISSING, miss);
         ncol = $urandom_range(2, 5);
         repeat (ncol) begin
            calm = $urandom_range(0, 3) == 0;
            elems.delete();
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 4)) elems.push_back(IDX_BITS'($urandom_range(0, 31)));
            end else begin
               for (int e = 0; e < ELEM_COUNT; e++) begin
                  if (mdl_mode == MODE_ENCODE)
                     take = (e < DATA_COUNT) ? $urandom_range(0, 3) != 0
                                             : $urandom_range(0, 7) == 0;
                  else
                     take = mdl_missing[e] ? $urandom_range(0, 7) == 0
                                           : $urandom_range(0, 7) != 0;
                  if (take) elems.push_back(IDX_BITS'(e));
               end
               if (elems.size() == 0)
                  elems.push_back(IDX_BITS'($urandom_range(0, ELEM_COUNT - 1)));
            end
            foreach (elems[k])
               send_beat(elems[k], {$urandom, $urandom}, k == elems.size() - 1, calm, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d element words (%0d folded in) in %0d columns and %0d register writes,",
               words_sent, useful_items, columns_closed, cfg_writes);
      $display("with %0d result beats checked across encode, decode and regenerate settings",
               results_seen);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #200000;
      $display("tb: failure");
      $finish;
   end

endmodule
